// ===== hdl/mspt_pkg.sv =====
// mspt_pkg: shared types and constants for the multi-slot periodic timer
// holds field widths, request kinds, sequencer states and the time unit request struct
// no dependencies
package mspt_pkg;

	localparam int SLOT_W         = 4;
	localparam int PERIOD_MS_W    = 23;
	localparam int PERIOD_US_W    = 32;
	localparam int TIME_W         = 64;
	localparam int US_PER_MS      = 1000;
	localparam int RESULT_CAP     = 16;
	localparam int NUM_TIMERS_DEF = 16;

	typedef enum logic [1:0] {
		KIND_START   = 2'd0,
		KIND_RESTART = 2'd1,
		KIND_STOP    = 2'd2,
		KIND_POLL    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RS_LOAD,
		ST_RS_CHECK,
		ST_RS_PULL,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_EMIT,
		ST_EMIT_NONE
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t                  op;
		logic [TIME_W-1:0]        a;
		logic [TIME_W-1:0]        b;
		logic [PERIOD_US_W-1:0]   lim;
	} alu_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic              gt;
	} alu_rsp_t;

endpackage

// ===== hdl/mspt_alu.sv =====
// mspt_alu: shared 64-bit add/subtract unit with compare against a 32-bit period
// used for elapsed-time checks and restart arithmetic
// depends on mspt_pkg
module mspt_alu (
	input  mspt_pkg::alu_req_t req,
	output mspt_pkg::alu_rsp_t rsp
);
	import mspt_pkg::*;

	logic [TIME_W-1:0] sum;

	always_comb begin
		case (req.op)
			ALU_ADD: sum = req.a + req.b;
			ALU_SUB: sum = req.a - req.b;
			default: sum = req.a - req.b;
		endcase
	end

	// result strictly beyond the period
	assign rsp.sum = sum;
	assign rsp.gt  = sum > TIME_W'(req.lim);

endmodule

// ===== hdl/mspt_slot_mem.sv =====
// mspt_slot_mem: per-slot start time and period storage, one write and one read port
// unwritten entries read as zero through per-entry valid bits
// depends on mspt_pkg
module mspt_slot_mem #(
	parameter int DEPTH = mspt_pkg::NUM_TIMERS_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [IDX_W-1:0]                 waddr,
	input  logic [mspt_pkg::TIME_W-1:0]      wstart,
	input  logic [mspt_pkg::PERIOD_US_W-1:0] wper,
	input  logic [IDX_W-1:0]                 raddr,
	output logic [mspt_pkg::TIME_W-1:0]      rd_start,
	output logic [mspt_pkg::PERIOD_US_W-1:0] rd_per
);
	import mspt_pkg::*;

	logic [TIME_W-1:0]      start_mem [DEPTH];
	logic [PERIOD_US_W-1:0] per_mem   [DEPTH];
	logic [DEPTH-1:0]       written_q;
	logic [TIME_W-1:0]      start_s1;
	logic [PERIOD_US_W-1:0] per_s1;
	logic                   valid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			per_mem[waddr]   <= wper;
		end
		start_s1 <= start_mem[raddr];
		per_s1   <= per_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			valid_s1 <= written_q[raddr];
		end
	end

	assign rd_start = valid_s1 ? start_s1 : '0;
	assign rd_per   = valid_s1 ? per_s1 : '0;

endmodule

// ===== hdl/multi_slot_periodic_timer.sv =====
// multi_slot_periodic_timer: table of periodic timer slots with start, restart, stop and poll
// start and stop go through dispatch only, restart through slot memory read, add, check and, on overrun, pull-up;
// poll scans one slot per cycle through the single memory read port and the shared 64-bit
// unit, then emits its responses, waiting on response stalls
// a new request is taken only in idle; a response sits in an output register meanwhile
// arst_n clears sequencer, running flags and memory valid bits; slots read as zero until written
module multi_slot_periodic_timer #(
	parameter int NUM_TIMERS = mspt_pkg::NUM_TIMERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request channel
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [1:0]                       kind,
	input  logic [mspt_pkg::SLOT_W-1:0]      slot,
	input  logic [mspt_pkg::PERIOD_MS_W-1:0] period_ms,
	input  logic [mspt_pkg::TIME_W-1:0]      now_us,
	// response channel
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [mspt_pkg::SLOT_W-1:0]      expired_slot,
	output logic                             fired,
	output logic                             last
);
	import mspt_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	// sequencer state
	state_t state_q, state_d;

	// latched request
	kind_t                  kind_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [PERIOD_MS_W-1:0] period_ms_q;
	logic [TIME_W-1:0]      now_q;

	// restart work registers
	logic [TIME_W-1:0]      acc_q;
	logic [PERIOD_US_W-1:0] per_q;

	// scan state
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      idx_s1;
	logic                  valid_s1;
	logic [NUM_TIMERS-1:0] hit_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      emitted_q;
	logic [NUM_TIMERS-1:0] running_q;

	// output register
	logic              rsp_valid_q;
	logic [SLOT_W-1:0] expired_slot_q;
	logic              fired_q;
	logic              last_q;

	// control from the output decode
	alu_req_t               alu_req;
	alu_rsp_t               alu_rsp;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_raddr;
	logic [TIME_W-1:0]      mem_wstart;
	logic [PERIOD_US_W-1:0] mem_wper;
	logic [TIME_W-1:0]      rd_start;
	logic [PERIOD_US_W-1:0] rd_per;
	logic                   run_set;
	logic                   run_clr;
	logic                   out_load;
	logic                   out_fired;
	logic                   out_last;

	logic              accept;
	logic              in_range;
	logic [IDX_W-1:0]  slot_idx;
	logic              eval_hit;
	logic              can_load;
	logic              emit_last;
	logic [31:0]       cap;

	assign accept   = req_valid && req_ready;
	// slots beyond the table are ignored by start, restart and stop
	assign in_range = 32'(slot_q) < NUM_TIMERS;
	assign slot_idx = IDX_W'(slot_q);
	assign can_load = !rsp_valid_q || rsp_ready;

	// scan pipeline evaluation: running and elapsed beyond period
	assign eval_hit = valid_s1 && running_q[idx_s1] && alu_rsp.gt;

	// at most RESULT_CAP fired responses per poll
	assign cap       = (32'(cnt_q) > RESULT_CAP) ? RESULT_CAP : 32'(cnt_q);
	assign emit_last = (32'(emitted_q) + 32'd1) == cap;

	mspt_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	mspt_slot_mem #(
		.DEPTH (NUM_TIMERS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (mem_we),
		.waddr    (slot_idx),
		.wstart   (mem_wstart),
		.wper     (mem_wper),
		.raddr    (mem_raddr),
		.rd_start (rd_start),
		.rd_per   (rd_per)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (kind_q)
					KIND_POLL:    state_d = ST_SCAN;
					KIND_RESTART: state_d = in_range ? ST_RS_LOAD : ST_IDLE;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_RS_LOAD:  state_d = ST_RS_CHECK;
			ST_RS_CHECK: state_d = alu_rsp.gt ? ST_RS_PULL : ST_IDLE;
			ST_RS_PULL:  state_d = ST_IDLE;
			ST_SCAN: begin
				if (idx_q == LAST_IDX) state_d = ST_SCAN_TAIL;
			end
			ST_SCAN_TAIL: begin
				state_d = ((cnt_q != '0) || eval_hit) ? ST_EMIT : ST_EMIT_NONE;
			end
			ST_EMIT: begin
				if (out_load && emit_last) state_d = ST_IDLE;
			end
			ST_EMIT_NONE: begin
				if (can_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output decode: memory, shared unit and response control
	always_comb begin
		req_ready  = 1'b0;
		alu_req    = '{op: ALU_SUB, a: now_q, b: rd_start, lim: rd_per};
		mem_we     = 1'b0;
		mem_raddr  = idx_q;
		mem_wstart = acc_q;
		mem_wper   = per_q;
		run_set    = 1'b0;
		run_clr    = 1'b0;
		out_load   = 1'b0;
		out_fired  = 1'b1;
		out_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_DISPATCH: begin
				mem_raddr = slot_idx;
				if (in_range && kind_q == KIND_START) begin
					mem_we     = 1'b1;
					mem_wstart = now_q;
					// period kept modulo 2^32
					mem_wper   = PERIOD_US_W'(33'(period_ms_q) * 33'(US_PER_MS));
					run_set    = 1'b1;
				end
				if (in_range && kind_q == KIND_STOP) begin
					run_clr = 1'b1;
				end
			end
			ST_RS_LOAD: begin
				// start time moves on by one period
				alu_req = '{op: ALU_ADD, a: rd_start, b: TIME_W'(rd_per), lim: rd_per};
			end
			ST_RS_CHECK: begin
				alu_req = '{op: ALU_SUB, a: now_q, b: acc_q, lim: per_q};
				if (!alu_rsp.gt) begin
					mem_we  = 1'b1;
					run_set = 1'b1;
				end
			end
			ST_RS_PULL: begin
				// overrun: start time becomes now minus period
				alu_req    = '{op: ALU_SUB, a: now_q, b: TIME_W'(per_q), lim: per_q};
				mem_we     = 1'b1;
				mem_wstart = alu_rsp.sum;
				run_set    = 1'b1;
			end
			ST_SCAN, ST_SCAN_TAIL: begin
				mem_raddr = idx_q;
			end
			ST_EMIT: begin
				if (hit_q[idx_q] && can_load) begin
					out_load = 1'b1;
					out_last = emit_last;
				end
			end
			ST_EMIT_NONE: begin
				if (can_load) begin
					out_load  = 1'b1;
					out_fired = 1'b0;
					out_last  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// request payload, restart work register and response payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= kind_t'(kind);
			slot_q      <= slot;
			period_ms_q <= period_ms;
			now_q       <= now_us;
		end
		if (state_q == ST_RS_LOAD) begin
			acc_q <= alu_rsp.sum;
			per_q <= rd_per;
		end
		if (out_load) begin
			expired_slot_q <= out_fired ? SLOT_W'(idx_q) : '0;
			fired_q        <= out_fired;
			last_q         <= out_last;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			idx_s1      <= '0;
			valid_s1    <= 1'b0;
			hit_q       <= '0;
			cnt_q       <= '0;
			emitted_q   <= '0;
			running_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SCAN);
			idx_s1   <= idx_q;

			if (run_set) running_q[slot_idx] <= 1'b1;
			if (run_clr) running_q[slot_idx] <= 1'b0;

			if (state_q == ST_DISPATCH) begin
				idx_q     <= '0;
				hit_q     <= '0;
				cnt_q     <= '0;
				emitted_q <= '0;
			end else if (state_q == ST_SCAN) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
			end else if (state_q == ST_EMIT) begin
				if (!hit_q[idx_q] || out_load) idx_q <= idx_q + IDX_W'(1);
			end

			if (eval_hit) begin
				hit_q[idx_s1] <= 1'b1;
				cnt_q         <= cnt_q + CNT_W'(1);
			end
			if (out_load && out_fired) emitted_q <= emitted_q + CNT_W'(1);

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign expired_slot = expired_slot_q;
	assign fired        = fired_q;
	assign last         = last_q;

endmodule

// ===== hdl/mspt_checker.sv =====
// mspt_checker: port-level checks for the multi-slot periodic timer, bound to the top level
// watches request and response channels only
// depends on mspt_pkg for widths
module mspt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [mspt_pkg::SLOT_W-1:0]      expired_slot,
	input logic                             fired,
	input logic                             last
);

	// a stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(expired_slot) && $stable(fired)
			&& $stable(last))
		else $error("stalled response changed");

	// the empty poll response is slot zero and final
	a_empty_poll: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !fired |-> last && expired_slot == '0)
		else $error("empty poll response malformed");

	// only fired responses can be followed by more
	a_nonlast_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> fired)
		else $error("non-final response without fired");

	// one request at a time: ready drops after every accepted request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind multi_slot_periodic_timer mspt_checker u_mspt_checker (.*);

// ===== sim/multi_slot_periodic_timer_tb.sv =====
// multi_slot_periodic_timer_tb: self-checking testbench for the periodic timer slot table
// drives start, restart, stop and poll requests with random idling on both channels and
// checks every expiry result against an in-bench predictor; depends on mspt_pkg and the rtl
module multi_slot_periodic_timer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mspt_pkg::*;

	localparam int NUM_SLOTS      = NUM_TIMERS_DEF;
	localparam int REQUEST_TARGET = 460;
	localparam int CYCLE_LIMIT    = 2_000_000;
	// a poll scans every slot then emits up to one result per slot
	localparam int SETTLE_CYCLES  = 2 * NUM_SLOTS + 32;
	localparam int REPORT_MAX     = 10;

	// one request as the sender presents it; hold makes the sender wait for a quiet block
	typedef struct {
		kind_t                  kind;
		logic [SLOT_W-1:0]      slot;
		logic [PERIOD_MS_W-1:0] period_ms;
		logic [TIME_W-1:0]      now_us;
		bit                     hold;
	} timer_request_t;

	// one expected expiry report
	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic              fired;
		logic              last;
	} expiry_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	kind_t                  kind      = KIND_POLL;
	logic [SLOT_W-1:0]      slot      = '0;
	logic [PERIOD_MS_W-1:0] period_ms = '0;
	logic [TIME_W-1:0]      now_us    = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	logic [SLOT_W-1:0]      expired_slot;
	logic                   fired;
	logic                   last;

	// predictor copy of the slot table
	logic                   slot_live    [NUM_SLOTS];
	logic [TIME_W-1:0]      slot_origin  [NUM_SLOTS];
	logic [PERIOD_US_W-1:0] slot_span_us [NUM_SLOTS];

	timer_request_t request_q[$];
	expiry_t        expiry_q[$];

	int pending_cnt = 0;   // expiry_q depth as of the previous edge
	int fault_cnt   = 0;
	int cycle_cnt   = 0;
	int req_gap     = 0;
	int rsp_stall   = 0;

	multi_slot_periodic_timer #(
		.NUM_TIMERS(NUM_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.kind(kind),
		.slot(slot),
		.period_ms(period_ms),
		.now_us(now_us),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.expired_slot(expired_slot),
		.fired(fired),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog, also the time base for the calm stretches
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, and a recurring calm window with none
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((cycle_cnt % 2048) < 300 || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TIME_W-1:0] rand_time64();
		return {$urandom(), $urandom()};
	endfunction

	// apply one accepted request to the slot table and queue what it must report
	function automatic void predict_request(timer_request_t rq);
		logic [TIME_W-1:0] span;
		expiry_t           hit;
		int                hits;
		hits = 0;
		case (rq.kind)
			KIND_START: begin
				slot_origin[rq.slot]  = rq.now_us;
				// period register is 32 bits wide, so large periods wrap
				slot_span_us[rq.slot] = PERIOD_US_W'(rq.period_ms * US_PER_MS);
				slot_live[rq.slot]    = 1'b1;
			end
			KIND_RESTART: begin
				span = TIME_W'(slot_span_us[rq.slot]);
				slot_origin[rq.slot] = slot_origin[rq.slot] + span;
				// overrun: pull the origin up to now minus one period
				if (rq.now_us - slot_origin[rq.slot] > span)
					slot_origin[rq.slot] = rq.now_us - span;
				slot_live[rq.slot] = 1'b1;
			end
			KIND_STOP: begin
				slot_live[rq.slot] = 1'b0;
			end
			default: begin
				// poll: ascending slot order, elapsed time wraps at 64 bits
				for (int i = 0; i < NUM_SLOTS; i++) begin
					span = TIME_W'(slot_span_us[i]);
					if (slot_live[i] && (rq.now_us - slot_origin[i] > span)) begin
						hit.slot  = SLOT_W'(i);
						hit.fired = 1'b1;
						hit.last  = 1'b0;
						expiry_q.push_back(hit);
						hits++;
					end
				end
				if (hits == 0) begin
					// nothing expired still yields one closing result
					hit.slot  = '0;
					hit.fired = 1'b0;
					hit.last  = 1'b1;
					expiry_q.push_back(hit);
				end else begin
					expiry_q[expiry_q.size() - 1].last = 1'b1;
				end
			end
		endcase
	endfunction

	function automatic void queue_request(kind_t k, int unsigned s, logic [PERIOD_MS_W-1:0] pms,
			logic [TIME_W-1:0] t, bit hold);
		timer_request_t rq;
		rq.kind      = k;
		rq.slot      = SLOT_W'(s);
		rq.period_ms = pms;
		rq.now_us    = t;
		rq.hold      = hold;
		request_q.push_back(rq);
	endfunction

	// request driver: valid stays up with a stable payload until accepted
	always @(posedge clk) begin
		timer_request_t head;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (req_gap > 0) begin
				req_gap   <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (request_q.size() > 0 &&
					(!request_q[0].hold || (!req_valid && pending_cnt == 0))) begin
				head = request_q.pop_front();
				req_valid <= 1'b1;
				kind      <= head.kind;
				slot      <= head.slot;
				period_ms <= head.period_ms;
				now_us    <= head.now_us;
				req_gap   <= draw_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response sink: random back-pressure, including while nothing is offered
	always @(posedge clk) begin
		int g;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall <= 0;
		end else if (rsp_valid && rsp_ready) begin
			g = draw_gap();
			rsp_ready <= (g == 0);
			rsp_stall <= (g > 0) ? g - 1 : 0;
		end else if (rsp_stall > 0) begin
			rsp_stall <= rsp_stall - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// monitor: check each result against the oldest expectation, then predict new requests
	always @(posedge clk) begin
		timer_request_t taken;
		expiry_t        want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expiry_q.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= REPORT_MAX)
						$display("[%0t] unexpected result: slot %0d fired %0b last %0b",
							$time, expired_slot, fired, last);
				end else begin
					want = expiry_q.pop_front();
					if (expired_slot !== want.slot || fired !== want.fired ||
							last !== want.last) begin
						fault_cnt++;
						if (fault_cnt <= REPORT_MAX) begin
							$display("[%0t] result mismatch: expected slot %0d fired %0b last %0b",
								$time, want.slot, want.fired, want.last);
							$display("[%0t] got slot %0d fired %0b last %0b",
								$time, expired_slot, fired, last);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				taken.kind      = kind;
				taken.slot      = slot;
				taken.period_ms = period_ms;
				taken.now_us    = now_us;
				taken.hold      = 1'b0;
				predict_request(taken);
			end
			pending_cnt <= expiry_q.size();
		end
	end

	initial begin
		logic [TIME_W-1:0] sys_now;
		logic [PERIOD_MS_W-1:0] pms;
		int issued;
		int r;
		int pick;

		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_live[i]    = 1'b0;
			slot_origin[i]  = '0;
			slot_span_us[i] = '0;
		end

		// directed: empty poll, restart of never-started slots, period edges, time wrap
		queue_request(KIND_POLL,    0, '0, 64'd0, 1'b0);
		queue_request(KIND_RESTART, 5, '0, 64'd0, 1'b0);
		queue_request(KIND_POLL,    0, '0, 64'd0, 1'b0);
		queue_request(KIND_POLL,    0, '0, 64'd1, 1'b0);
		queue_request(KIND_RESTART, 7, '0, 64'd1000, 1'b0);
		queue_request(KIND_START,   0, '0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
		// all-ones period wraps the 32-bit microsecond register
		queue_request(KIND_START,   15, '1, '1, 1'b0);
		queue_request(KIND_START,   1, PERIOD_MS_W'(4294967), 64'd2000, 1'b0);
		queue_request(KIND_START,   2, PERIOD_MS_W'(1), 64'd100, 1'b0);
		queue_request(KIND_POLL,    9, '0, 64'd1100, 1'b0);
		queue_request(KIND_POLL,    0, '0, 64'd1101, 1'b0);
		queue_request(KIND_RESTART, 2, '0, 64'd1101, 1'b0);
		queue_request(KIND_RESTART, 2, '0, 64'd50000, 1'b0);
		queue_request(KIND_STOP,    5, '0, 64'd50000, 1'b1);
		queue_request(KIND_STOP,    7, '0, 64'd50000, 1'b0);
		queue_request(KIND_STOP,    0, '0, 64'd50000, 1'b0);
		queue_request(KIND_POLL,    0, '0, 64'd50000, 1'b0);
		queue_request(KIND_POLL,    0, '0, '1, 1'b0);
		queue_request(KIND_START,   3, PERIOD_MS_W'(2), 64'hFFFF_FFFF_FFFF_FC00, 1'b0);
		queue_request(KIND_POLL,    0, '0, 64'h500, 1'b0);
		queue_request(KIND_RESTART, 3, '0, 64'h500, 1'b0);
		queue_request(KIND_STOP,    15, '1, 64'h500, 1'b0);
		queue_request(KIND_STOP,    1, '0, 64'h500, 1'b0);
		queue_request(KIND_POLL,    0, '0, 64'h600, 1'b0);
		issued = request_q.size();

		// random: a running system clock with mostly short periods so polls see expiries
		sys_now = rand_time64() & 64'h0000_00FF_FFFF_FFFF;
		while (issued < REQUEST_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				// reload every slot with a tiny period, then poll past them all
				for (int i = 0; i < NUM_SLOTS; i++) begin
					queue_request(KIND_START, i, PERIOD_MS_W'($urandom_range(0, 3)),
						sys_now, 1'b0);
					sys_now += $urandom_range(0, 50);
				end
				sys_now += $urandom_range(3000, 6000);
				queue_request(KIND_POLL, 0, '0, sys_now, 1'b0);
				issued += NUM_SLOTS + 1;
			end else if (r < 7) begin
				// noise: any kind, any field value
				queue_request(kind_t'($urandom_range(0, 3)), $urandom_range(0, NUM_SLOTS - 1),
					PERIOD_MS_W'($urandom()), rand_time64(), 1'b0);
				issued++;
			end else begin
				if (r < 8)
					sys_now = '1 - TIME_W'($urandom_range(0, 20000));   // cross the wrap
				else if (r < 15)
					sys_now += $urandom_range(0, 20000);
				else
					sys_now += $urandom_range(0, 1500);
				pick = $urandom_range(0, 99);
				if (pick < 80)
					pms = PERIOD_MS_W'($urandom_range(0, 5));
				else if (pick < 95)
					pms = PERIOD_MS_W'($urandom_range(0, 4294967));
				else
					pms = PERIOD_MS_W'($urandom());
				pick = $urandom_range(0, 99);
				if (pick < 20)
					queue_request(KIND_START, $urandom_range(0, NUM_SLOTS - 1), pms, sys_now,
						($urandom_range(0, 29) == 0));
				else if (pick < 40)
					queue_request(KIND_RESTART, $urandom_range(0, NUM_SLOTS - 1), pms, sys_now,
						($urandom_range(0, 29) == 0));
				else if (pick < 50)
					queue_request(KIND_STOP, $urandom_range(0, NUM_SLOTS - 1), pms, sys_now,
						($urandom_range(0, 29) == 0));
				else
					queue_request(KIND_POLL, $urandom_range(0, NUM_SLOTS - 1), pms, sys_now,
						($urandom_range(0, 29) == 0));
				issued++;
			end
		end

		// single reset at the start, released away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to be taken and every expected result to arrive
		do
			@(negedge clk);
		while (request_q.size() != 0 || req_valid || pending_cnt != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (expiry_q.size() != 0) begin
			$display("%0d expected results never arrived", expiry_q.size());
			fault_cnt += expiry_q.size();
		end
		if (fault_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
